FILE: hw/rtl/cswg_pkg.sv
package cswg_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int OUT_W       = 18;

  // Parameter defaults
  localparam int PHASE_BITS_DEF      = 16;
  localparam int COS_TABLE_DEPTH_DEF = 1024;
  localparam int COEF_BITS_DEF       = 16;

  // Register reset values
  localparam logic [SAMPLE_W-1:0]   WINDOW_LENGTH_RST = 16'd256;
  localparam logic                  PERIODIC_MODE_RST = 1'b1;
  localparam logic signed [15:0]    COEF_ZERO_RST     = 16'sd16384;
  localparam logic signed [15:0]    COEF_ONE_RST      = 16'sd16384;
  localparam logic signed [15:0]    COEF_TWO_RST      = 16'sd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_LENGTH,
    CFG_PERIODIC_MODE,
    CFG_COEF_ZERO,
    CFG_COEF_ONE,
    CFG_COEF_TWO
  } cfg_reg_t;

  typedef struct packed {
    logic last;
    logic oor;
  } item_flags_t;

endpackage

FILE: hw/rtl/cswg_phase_div.sv
module cswg_phase_div #(
  parameter int PHASE_BITS = cswg_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cswg_pkg::SAMPLE_W-1:0] sample_index,
  input  logic [cswg_pkg::SAMPLE_W-1:0] den,
  output logic [PHASE_BITS-1:0]         phase
);

  import cswg_pkg::*;

  localparam int W     = SAMPLE_W;
  localparam int EXT_W = PHASE_BITS + W;

  // Rounding term den/2 split into the part above the binary point of the
  // phase and the bits that are shifted in during the quotient steps.
  logic [EXT_W-1:0]      half_ext;
  logic [W-1:0]          half_hi;
  logic [PHASE_BITS-1:0] half_lo;

  assign half_ext = EXT_W'(den >> 1);
  assign half_hi  = half_ext[EXT_W-1:PHASE_BITS];
  assign half_lo  = half_ext[PHASE_BITS-1:0];

  // Remainder stages: n mod den, one dividend bit per stage
  logic [W-1:0] md_n   [W];
  logic [W-1:0] md_rem [1:W];

  always_ff @(posedge clk) begin
    if (en) begin
      md_n[0] <= sample_index;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_mod
    logic [W-1:0] rem_prev;
    logic [W:0]   trial;
    logic         take;

    if (k == 1) begin : g_first
      assign rem_prev = '0;
    end else begin : g_rest
      assign rem_prev = md_rem[k-1];
    end

    assign trial = {rem_prev, md_n[k-1][W-k]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        md_rem[k] <= take ? W'(trial - {1'b0, den}) : trial[W-1:0];
      end
    end

    if (k < W) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          md_n[k] <= md_n[k-1];
        end
      end
    end
  end

  // Fold the high part of the rounding term into the remainder; the carry
  // into bit PHASE_BITS of the quotient wraps away.
  logic [W:0] hi_sum;

  assign hi_sum = {1'b0, md_rem[W]} + {1'b0, half_hi};

  logic [W-1:0]          dv_rem [PHASE_BITS];
  logic [PHASE_BITS-1:0] dv_q   [1:PHASE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= (hi_sum >= {1'b0, den}) ? W'(hi_sum - {1'b0, den}) : hi_sum[W-1:0];
    end
  end

  // Quotient stages: one phase bit per stage
  for (genvar j = 1; j <= PHASE_BITS; j++) begin : g_div
    logic [PHASE_BITS-1:0] q_prev;
    logic [W:0]            trial;
    logic                  take;

    if (j == 1) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = dv_q[j-1];
    end

    assign trial = {dv_rem[j-1], half_lo[PHASE_BITS-j]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j] <= {q_prev[PHASE_BITS-2:0], take};
      end
    end

    if (j < PHASE_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[j] <= take ? W'(trial - {1'b0, den}) : trial[W-1:0];
        end
      end
    end
  end

  assign phase = dv_q[PHASE_BITS];

endmodule

FILE: hw/rtl/cosine_sum_window_generator_unit.sv
// Channel   Signals                                     Direction  Carries
// ------    ------------------------------------------  ---------  ------------------------
// in        in_valid, in_ready, sample_index            input      one index per request
// out       out_valid, out_ready, window_value,         output     window sample and flags
//           last_sample, index_out_of_range
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   input      register writes
//
// One request per cycle while in_ready is high; the pipeline depth is set by the
// restoring divider that spends one stage per remainder bit (16) and per phase bit.
// Reset restores the register defaults and empties the pipeline; the cosine table is
// constant, so no clearing pass is needed. When the output stalls, a skid register
// absorbs one result and in_ready drops until it drains; the whole pipeline then holds.
module cosine_sum_window_generator_unit #(
  parameter int PHASE_BITS      = cswg_pkg::PHASE_BITS_DEF,
  parameter int COS_TABLE_DEPTH = cswg_pkg::COS_TABLE_DEPTH_DEF,
  parameter int COEF_BITS       = cswg_pkg::COEF_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [cswg_pkg::SAMPLE_W-1:0]          sample_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cswg_pkg::OUT_W-1:0]      window_value,
  output logic                                   last_sample,
  output logic                                   index_out_of_range,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cswg_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [cswg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import cswg_pkg::*;

  localparam int DIV_STAGES = PHASE_BITS + 18;
  localparam int ST_L1      = DIV_STAGES;
  localparam int ST_L2      = DIV_STAGES + 1;
  localparam int ST_L3      = DIV_STAGES + 2;
  localparam int ST_MUL     = DIV_STAGES + 3;
  localparam int ST_SUM     = DIV_STAGES + 4;
  localparam int ST_RND     = DIV_STAGES + 5;
  localparam int NST        = DIV_STAGES + 6;

  localparam int IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int MW      = PHASE_BITS - 2 + IDX_W;
  localparam int C_W     = 17;
  localparam int PW      = COEF_BITS + C_W;
  localparam int ACC_W   = PW + 2;
  localparam int SHL     = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
  localparam int SHR     = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
  localparam int CX_W    = 16 + SHL;

  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned TWO_DEPTH = 64'(2 * COS_TABLE_DEPTH);
  localparam longint          ONE_Q30   = 64'sd1073741824;

  localparam logic signed [ACC_W-1:0] RND_ADD = ACC_W'(2 ** (COEF_BITS - 2));
  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(131071);
  localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(-131072);

  // Cosine table construction, evaluated at elaboration
  function automatic longint unsigned taylor_mul(input longint unsigned x2,
                                                  input longint unsigned t);
    return (x2 * t + 64'd536870912) >> 30;
  endfunction

  function automatic longint clamp_pos(input longint v);
    return (v < 0) ? 64'sd0 : v;
  endfunction

  function automatic logic [15:0] cos_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint          t;
    x  = (PI_Q30 * k + 64'(COS_TABLE_DEPTH)) / TWO_DEPTH;
    x2 = (x * x + 64'd536870912) >> 30;
    t  = ONE_Q30;
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd182));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd132));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd90));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd56));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd30));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd12));
    t  = clamp_pos(ONE_Q30 - $signed(taylor_mul(x2, $unsigned(t)) / 64'd2));
    return 16'(($unsigned(t) + 64'd16384) >> 15);
  endfunction

  // Q1.15 register to Q1.(COEF_BITS-1), flooring when narrowing
  function automatic logic signed [COEF_BITS-1:0] coef_conv(input logic signed [15:0] c);
    logic signed [CX_W-1:0] e;
    e = CX_W'(c) <<< SHL;
    return COEF_BITS'(e >>> SHR);
  endfunction

  // Configuration registers
  logic [SAMPLE_W-1:0]    window_length;
  logic                   periodic_mode;
  logic signed [15:0]     coef_zero;
  logic signed [15:0]     coef_one;
  logic signed [15:0]     coef_two;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      periodic_mode <= PERIODIC_MODE_RST;
      coef_zero     <= COEF_ZERO_RST;
      coef_one      <= COEF_ONE_RST;
      coef_two      <= COEF_TWO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_LENGTH: window_length <= cfg_data;
        CFG_PERIODIC_MODE: periodic_mode <= cfg_data[0];
        CFG_COEF_ZERO:     coef_zero     <= $signed(cfg_data);
        CFG_COEF_ONE:      coef_one      <= $signed(cfg_data);
        CFG_COEF_TWO:      coef_two      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Register-derived; the user must change them only while the block is idle (not checked)
  logic [SAMPLE_W-1:0]          den;
  logic                         den_zero;
  logic signed [COEF_BITS-1:0]  a0;
  logic signed [COEF_BITS-1:0]  a1;
  logic signed [COEF_BITS-1:0]  a2;

  always_ff @(posedge clk) begin
    if (periodic_mode) begin
      den      <= window_length;
      den_zero <= (window_length == '0);
    end else begin
      den      <= (window_length != '0) ? window_length - 1'b1 : '0;
      den_zero <= (window_length <= SAMPLE_W'(1));
    end
    a0 <= coef_conv(coef_zero);
    a1 <= coef_conv(coef_one);
    a2 <= coef_conv(coef_two);
  end

  // Pipeline control: everything advances unless the skid register is full
  logic              en;
  logic [NST-1:0]    vld;
  item_flags_t       flg [NST];
  item_flags_t       flags_in;

  logic                                skid_valid;
  logic signed [OUT_W-1:0]             skid_value;
  item_flags_t                         skid_flags;
  logic                                out_take;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign out_take = !out_valid || out_ready;

  assign flags_in.last = (window_length != '0) && (sample_index == window_length - 1'b1);
  assign flags_in.oor  = (sample_index >= window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg[0] <= flags_in;
      for (int s = 1; s < NST; s++) begin
        flg[s] <= flg[s-1];
      end
    end
  end

  // Phase = round(2^PHASE_BITS * (n mod D) / D)
  logic [PHASE_BITS-1:0] phase;

  cswg_phase_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_div (
    .clk          (clk),
    .en           (en),
    .sample_index (sample_index),
    .den          (den),
    .phase        (phase)
  );

  // Stage L1: table index for both harmonics
  logic [PHASE_BITS-1:0] ph1;
  logic [PHASE_BITS-1:0] ph2;
  logic [MW-1:0]         prod1;
  logic [MW-1:0]         prod2;
  logic [IDX_W-1:0]      l1_i1;
  logic [IDX_W-1:0]      l1_i2;
  logic [1:0]            l1_q1;
  logic [1:0]            l1_q2;

  always_comb begin
    ph1   = den_zero ? '0 : phase;
    ph2   = {ph1[PHASE_BITS-2:0], 1'b0};
    prod1 = MW'(ph1[PHASE_BITS-3:0]) * MW'(COS_TABLE_DEPTH) + MW'(2 ** (PHASE_BITS - 3));
    prod2 = MW'(ph2[PHASE_BITS-3:0]) * MW'(COS_TABLE_DEPTH) + MW'(2 ** (PHASE_BITS - 3));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_i1 <= IDX_W'(prod1 >> (PHASE_BITS - 2));
      l1_i2 <= IDX_W'(prod2 >> (PHASE_BITS - 2));
      l1_q1 <= ph1[PHASE_BITS-1:PHASE_BITS-2];
      l1_q2 <= ph2[PHASE_BITS-1:PHASE_BITS-2];
    end
  end

  // Stage L2: quadrant folding into a table address and a sign
  logic [IDX_W-1:0] l2_a1;
  logic [IDX_W-1:0] l2_a2;
  logic             l2_n1;
  logic             l2_n2;

  always_ff @(posedge clk) begin
    if (en) begin
      l2_a1 <= l1_q1[0] ? IDX_W'(COS_TABLE_DEPTH) - l1_i1 : l1_i1;
      l2_a2 <= l1_q2[0] ? IDX_W'(COS_TABLE_DEPTH) - l1_i2 : l1_i2;
      l2_n1 <= l1_q1[1] ^ l1_q1[0];
      l2_n2 <= l1_q2[1] ^ l1_q2[0];
    end
  end

  // Stage L3: quarter-wave cosine table, two read ports
  logic [15:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    assign cos_rom[k] = cos_entry(64'(k));
  end

  logic [15:0] l3_m1;
  logic [15:0] l3_m2;
  logic        l3_n1;
  logic        l3_n2;

  always_ff @(posedge clk) begin
    if (en) begin
      l3_m1 <= cos_rom[l2_a1];
      l3_m2 <= cos_rom[l2_a2];
      l3_n1 <= l2_n1;
      l3_n2 <= l2_n2;
    end
  end

  // Stage MUL: coefficient products
  logic signed [C_W-1:0] c1;
  logic signed [C_W-1:0] c2;
  logic signed [PW-1:0]  p0;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;

  always_comb begin
    c1 = l3_n1 ? -$signed({1'b0, l3_m1}) : $signed({1'b0, l3_m1});
    c2 = l3_n2 ? -$signed({1'b0, l3_m2}) : $signed({1'b0, l3_m2});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= PW'(a0) <<< 15;
      p1 <= PW'(a1) * PW'(c1);
      p2 <= PW'(a2) * PW'(c2);
    end
  end

  // Stage SUM
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= ACC_W'(p0) - ACC_W'(p1) + ACC_W'(p2);
    end
  end

  // Stage RND: round to Q3.15 and saturate
  logic signed [ACC_W-1:0] rnd;
  logic signed [OUT_W-1:0] w_next;
  logic signed [OUT_W-1:0] r_value;

  always_comb begin
    rnd = (acc + RND_ADD) >>> (COEF_BITS - 1);
    priority if (rnd > SAT_HI) begin
      w_next = OUT_W'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      w_next = OUT_W'(SAT_LO);
    end else begin
      w_next = OUT_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_value <= w_next;
    end
  end

  // Output register with a one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[ST_RND]) begin
      if (out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        window_value       <= skid_value;
        last_sample        <= skid_flags.last;
        index_out_of_range <= skid_flags.oor;
      end
    end else if (vld[ST_RND]) begin
      if (out_take) begin
        window_value       <= r_value;
        last_sample        <= flg[ST_RND].last;
        index_out_of_range <= flg[ST_RND].oor;
      end else begin
        skid_value <= r_value;
        skid_flags <= flg[ST_RND];
      end
    end
  end

endmodule
